// ===== src/lobm_pkg.sv =====
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and constants for the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;
    localparam int BOOK_DEPTH = 16;
    localparam int TAG_BITS   = 16;
    localparam int IDX_W      = $clog2(BOOK_DEPTH);
    localparam int VAL_W      = 31;
    localparam int STAMP_W    = 32;
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    localparam logic [1:0] FUNC_SUBMIT = 2'd0;
    localparam logic [1:0] FUNC_CANCEL = 2'd1;
    localparam logic [1:0] FUNC_MODIFY = 2'd2;
    localparam logic [1:0] FUNC_PRINT  = 2'd3;

    localparam logic [2:0] KIND_TRADE     = 3'd0;
    localparam logic [2:0] KIND_SELL_HDR  = 3'd1;
    localparam logic [2:0] KIND_SELL_LVL  = 3'd2;
    localparam logic [2:0] KIND_BUY_HDR   = 3'd3;
    localparam logic [2:0] KIND_BUY_LVL   = 3'd4;
    localparam logic [2:0] KIND_REJECT    = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE, S_FIND, S_MSCAN, S_MFILL, S_REST,
        S_PHDR, S_PSCAN, S_PSUM, S_DONE
    } t_state;

    typedef struct packed {
        logic                sell;
        logic [VAL_W-1:0]    price;
        logic [VAL_W-1:0]    qty;
        logic [TAG_BITS-1:0] tag;
        logic [STAMP_W-1:0]  stamp;
    } t_entry;

    typedef struct packed {
        logic             wr_new;
        logic             wr_upd;
        logic             clr;
        logic [IDX_W-1:0] idx;
        t_entry           ent;
    } t_bwr;

    typedef struct packed {
        logic [2:0]          kind;
        logic [TAG_BITS-1:0] rtag;
        logic [VAL_W-1:0]    rprice;
        logic [VAL_W-1:0]    fqty;
        logic [TAG_BITS-1:0] itag;
        logic [VAL_W-1:0]    iprice;
        logic [VAL_W-1:0]    lprice;
        logic [VAL_W-1:0]    lqty;
    } t_res;
endpackage

// ===== src/lobm_book.sv =====
// ----------------------------------------------------------------------------
// lobm_book
// Resting order table: valid flags, entry fields, one scan read, one write.
// ----------------------------------------------------------------------------
module lobm_book import lobm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IDX_W-1:0]      i_rd_idx,
    input  t_bwr                  i_wr,
    output t_entry                o_rd,
    output logic [BOOK_DEPTH-1:0] o_valid
);
    logic [BOOK_DEPTH-1:0] r_valid;
    t_entry                r_mem [BOOK_DEPTH];
    t_entry                r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.wr_new) begin
            r_valid[i_wr.idx] <= 1'b1;
        end else if (i_wr.clr) begin
            r_valid[i_wr.idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_new) begin
            r_mem[i_wr.idx] <= i_wr.ent;
        end else if (i_wr.wr_upd) begin
            r_mem[i_wr.idx].qty   <= i_wr.ent.qty;
            r_mem[i_wr.idx].stamp <= i_wr.ent.stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_rd_idx];
    end

    assign o_rd    = r_rd;
    assign o_valid = r_valid;
endmodule

// ===== src/lobm_emit.sv =====
// ----------------------------------------------------------------------------
// lobm_emit
// Result output stage: holds one pending word so the final one gets last.
// ----------------------------------------------------------------------------
module lobm_emit import lobm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_emit,
    input  t_res                i_res,
    input  logic                i_flush,
    output logic                o_valid,
    output logic                o_last,
    output t_res                o_res
);
    logic r_pend_v;
    t_res r_pend;
    logic r_out_v;
    logic r_out_last;
    t_res r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else if (i_emit) begin
            r_pend_v <= 1'b1;
            r_out_v  <= r_pend_v;
        end else if (i_flush) begin
            r_pend_v <= 1'b0;
            r_out_v  <= r_pend_v;
        end else begin
            r_out_v  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit) begin
            r_pend     <= i_res;
            r_out      <= r_pend;
            r_out_last <= 1'b0;
        end else if (i_flush) begin
            r_out      <= r_pend;
            r_out_last <= 1'b1;
        end
    end

    assign o_valid = r_out_v;
    assign o_last  = r_out_last;
    assign o_res   = r_out;
endmodule

// ===== src/limit_order_book_matcher.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority matcher over a table of resting orders, one scan
// compare unit stepping through the table under a small sequencer.
// ----------------------------------------------------------------------------
// Sequence: a tag scan of the table, then one table scan per fill search,
// then the rest and done states; print scans the table twice per level plus
// once per side, then finishes. The table scan sets the pace.
// Throughput: one command at a time; busy falls as the last word, if any, is shown.
// Results cannot be stalled. Reset clears the book and the stamp counter.
module limit_order_book_matcher import lobm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_func,
    input  logic                i_side_sell,
    input  logic                i_immediate,
    input  logic [VAL_W-1:0]    i_limit_price,
    input  logic [VAL_W-1:0]    i_order_qty,
    input  logic [TAG_BITS-1:0] i_order_tag,
    output logic                o_valid,
    output logic [2:0]          o_kind,
    output logic [TAG_BITS-1:0] o_resting_tag,
    output logic [VAL_W-1:0]    o_resting_price,
    output logic [VAL_W-1:0]    o_fill_qty,
    output logic [TAG_BITS-1:0] o_incoming_tag,
    output logic [VAL_W-1:0]    o_incoming_price,
    output logic [VAL_W-1:0]    o_level_price,
    output logic [VAL_W-1:0]    o_level_qty,
    output logic                o_last
);
    t_state r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [1:0]          r_func, n_func;
    logic                r_sell, n_sell;
    logic                r_imm, n_imm;
    logic [VAL_W-1:0]    r_price, n_price;
    logic [VAL_W-1:0]    r_rem, n_rem;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic                r_found, n_found;
    logic [IDX_W-1:0]    r_fidx, n_fidx;
    logic                r_bfound, n_bfound;
    logic [IDX_W-1:0]    r_bidx, n_bidx;
    t_entry              r_best, n_best;
    logic [STAMP_W-1:0]  r_stamp, n_stamp;
    logic                r_hbound, n_hbound;
    logic [VAL_W-1:0]    r_lvl, n_lvl;
    logic [VAL_W-1:0]    r_sum, n_sum;

    t_entry                rd;
    logic [BOOK_DEPTH-1:0] vld;
    t_bwr                  wr;
    logic                  emit, flush;
    t_res                  res, out_res;
    logic                  last_idx;
    logic                  cur_v;
    logic                  crosses, better;
    logic                  free_f;
    logic [IDX_W-1:0]      free_i;
    logic [VAL_W:0]        sum_w;

    lobm_book u_book (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_rd_idx(n_idx), .i_wr(wr),
        .o_rd(rd), .o_valid(vld)
    );

    lobm_emit u_emit (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_emit(emit), .i_res(res),
        .i_flush(flush), .o_valid(o_valid), .o_last(o_last), .o_res(out_res)
    );

    assign o_kind           = out_res.kind;
    assign o_resting_tag    = out_res.rtag;
    assign o_resting_price  = out_res.rprice;
    assign o_fill_qty       = out_res.fqty;
    assign o_incoming_tag   = out_res.itag;
    assign o_incoming_price = out_res.iprice;
    assign o_level_price    = out_res.lprice;
    assign o_level_qty      = out_res.lqty;
    assign busy             = (r_state != S_IDLE);

    always_comb begin
        free_f = 1'b0;
        free_i = '0;
        for (int k = BOOK_DEPTH - 1; k >= 0; k--) begin
            if (!vld[k]) begin
                free_f = 1'b1;
                free_i = IDX_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stamp <= '0;
        end else begin
            r_state <= n_state;
            r_stamp <= n_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_func   <= n_func;
        r_sell   <= n_sell;
        r_imm    <= n_imm;
        r_price  <= n_price;
        r_rem    <= n_rem;
        r_tag    <= n_tag;
        r_found  <= n_found;
        r_fidx   <= n_fidx;
        r_bfound <= n_bfound;
        r_bidx   <= n_bidx;
        r_best   <= n_best;
        r_hbound <= n_hbound;
        r_lvl    <= n_lvl;
        r_sum    <= n_sum;
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_func   = r_func;
        n_sell   = r_sell;
        n_imm    = r_imm;
        n_price  = r_price;
        n_rem    = r_rem;
        n_tag    = r_tag;
        n_found  = r_found;
        n_fidx   = r_fidx;
        n_bfound = r_bfound;
        n_bidx   = r_bidx;
        n_best   = r_best;
        n_stamp  = r_stamp;
        n_hbound = r_hbound;
        n_lvl    = r_lvl;
        n_sum    = r_sum;
        wr       = '0;
        emit     = 1'b0;
        flush    = 1'b0;
        res      = '0;
        last_idx = (r_idx == IDX_W'(BOOK_DEPTH - 1));
        cur_v    = vld[r_idx];
        crosses  = r_sell ? (rd.price >= r_price) : (rd.price <= r_price);
        better   = !r_bfound
                   || ((rd.price == r_best.price) && (rd.stamp < r_best.stamp))
                   || (r_sell ? (rd.price > r_best.price) : (rd.price < r_best.price));
        sum_w    = {1'b0, r_sum} + {1'b0, rd.qty};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func  = i_func;
                    n_sell  = i_side_sell;
                    n_imm   = (i_func == FUNC_SUBMIT) ? i_immediate : 1'b0;
                    n_price = i_limit_price;
                    n_rem   = i_order_qty;
                    n_tag   = i_order_tag;
                    n_idx   = '0;
                    n_found = 1'b0;
                    if (i_func == FUNC_PRINT) begin
                        n_sell  = 1'b1;
                        n_state = S_PHDR;
                    end else begin
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                if (cur_v && (rd.tag == r_tag) && !r_found) begin
                    n_found = 1'b1;
                    n_fidx  = r_idx;
                end
                n_idx = r_idx + 1'b1;
                if (last_idx) begin
                    n_idx    = '0;
                    n_bfound = 1'b0;
                    n_state  = S_DONE;
                    case (r_func)
                        FUNC_SUBMIT: begin
                            if ((r_price != '0) && (r_rem != '0) && !n_found) begin
                                n_state = S_MSCAN;
                            end
                        end
                        FUNC_CANCEL: begin
                            wr.clr = n_found;
                            wr.idx = n_fidx;
                        end
                        FUNC_MODIFY: begin
                            if ((r_price != '0) && (r_rem != '0) && n_found) begin
                                wr.clr  = 1'b1;
                                wr.idx  = n_fidx;
                                n_state = S_MSCAN;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_MSCAN: begin
                if (cur_v && (rd.sell != r_sell) && crosses && better) begin
                    n_bfound = 1'b1;
                    n_bidx   = r_idx;
                    n_best   = rd;
                end
                n_idx = r_idx + 1'b1;
                if (last_idx) begin
                    n_idx   = '0;
                    n_state = S_MFILL;
                end
            end
            S_MFILL: begin
                res.kind   = KIND_TRADE;
                res.rtag   = r_best.tag;
                res.rprice = r_best.price;
                res.itag   = r_tag;
                res.iprice = r_price;
                n_bfound   = 1'b0;
                if (!r_bfound) begin
                    n_state = S_REST;
                end else if (r_best.qty > r_rem) begin
                    wr.wr_upd    = 1'b1;
                    wr.idx       = r_bidx;
                    wr.ent.qty   = r_best.qty - r_rem;
                    wr.ent.stamp = r_stamp;
                    n_stamp      = r_stamp + 1'b1;
                    res.fqty     = r_rem;
                    emit         = 1'b1;
                    n_rem        = '0;
                    n_state      = S_DONE;
                end else begin
                    wr.clr   = 1'b1;
                    wr.idx   = r_bidx;
                    res.fqty = r_best.qty;
                    emit     = 1'b1;
                    n_rem    = r_rem - r_best.qty;
                    n_state  = (n_rem == '0) ? S_DONE : S_MSCAN;
                end
            end
            S_REST: begin
                n_state = S_DONE;
                if ((r_rem != '0) && !r_imm) begin
                    if (!free_f) begin
                        res.kind   = KIND_REJECT;
                        res.itag   = r_tag;
                        res.iprice = r_price;
                        emit       = 1'b1;
                    end else begin
                        wr.wr_new    = 1'b1;
                        wr.idx       = free_i;
                        wr.ent.sell  = r_sell;
                        wr.ent.price = r_price;
                        wr.ent.qty   = r_rem;
                        wr.ent.tag   = r_tag;
                        wr.ent.stamp = r_stamp;
                        n_stamp      = r_stamp + 1'b1;
                    end
                end
            end
            S_PHDR: begin
                res.kind = r_sell ? KIND_SELL_HDR : KIND_BUY_HDR;
                emit     = 1'b1;
                n_hbound = 1'b0;
                n_lvl    = '0;
                n_found  = 1'b0;
                n_idx    = '0;
                n_state  = S_PSCAN;
            end
            S_PSCAN: begin
                if (cur_v && (rd.sell == r_sell) && (!r_hbound || (rd.price < r_price))
                    && (!r_found || (rd.price > r_lvl))) begin
                    n_found = 1'b1;
                    n_lvl   = rd.price;
                end
                n_idx = r_idx + 1'b1;
                if (last_idx) begin
                    n_idx = '0;
                    n_sum = '0;
                    if (n_found) begin
                        n_state = S_PSUM;
                    end else if (r_sell) begin
                        n_sell  = 1'b0;
                        n_state = S_PHDR;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_PSUM: begin
                if (cur_v && (rd.sell == r_sell) && (rd.price == r_lvl)) begin
                    n_sum = sum_w[VAL_W] ? VAL_MAX : sum_w[VAL_W-1:0];
                end
                n_idx = r_idx + 1'b1;
                if (last_idx) begin
                    n_idx      = '0;
                    res.kind   = r_sell ? KIND_SELL_LVL : KIND_BUY_LVL;
                    res.lprice = r_lvl;
                    res.lqty   = n_sum;
                    emit       = 1'b1;
                    n_price    = r_lvl;
                    n_hbound   = 1'b1;
                    n_found    = 1'b0;
                    n_state    = S_PSCAN;
                end
            end
            S_DONE: begin
                flush   = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// ===== src/lobm_checker.sv =====
// ----------------------------------------------------------------------------
// lobm_checker
// Port-level checks on command acceptance, result words and reset.
// ----------------------------------------------------------------------------
module lobm_checker import lobm_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic       o_last,
    input logic [2:0] o_kind
);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("busy not raised after accept");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy) else $error("non-final word while idle");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid) else $error("word right after last");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_kind <= KIND_REJECT)) else $error("bad result kind");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy) else $error("activity after reset");
endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_last(o_last), .o_kind(o_kind)
);

// ===== dv/limit_order_book_matcher_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher_test
// Self-checking bench for the order book matcher. A directed table covers
// the empty book, the ignored commands, duplicate tags, price extremes and
// level saturation. Random rounds then fill the book, cross it, cancel,
// modify and print. Each result word is checked against a behavioral book or a fixed list.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_test;
    import lobm_pkg::*;

    localparam int WATCH_LIMIT = 20000;
    localparam int N_RANDOM    = 310;
    localparam int QUIET_TAIL  = 40;

    // how a directed row is checked
    localparam int CHK_MODEL  = 0;
    localparam int CHK_NONE   = 1;
    localparam int CHK_EMPTY  = 2;
    localparam int CHK_SAT100 = 3;

    typedef struct {
        logic [1:0]          func;
        logic                sell;
        logic                imm;
        logic [VAL_W-1:0]    price;
        logic [VAL_W-1:0]    qty;
        logic [TAG_BITS-1:0] tag;
        int                  chk;
    } t_cmd;

    typedef struct {
        t_res r;
        logic last;
    } t_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          i_func = FUNC_PRINT;
    logic                i_side_sell = 1'b0;
    logic                i_immediate = 1'b0;
    logic [VAL_W-1:0]    i_limit_price = '0;
    logic [VAL_W-1:0]    i_order_qty = '0;
    logic [TAG_BITS-1:0] i_order_tag = '0;
    logic                o_valid;
    logic [2:0]          o_kind;
    logic [TAG_BITS-1:0] o_resting_tag;
    logic [VAL_W-1:0]    o_resting_price;
    logic [VAL_W-1:0]    o_fill_qty;
    logic [TAG_BITS-1:0] o_incoming_tag;
    logic [VAL_W-1:0]    o_incoming_price;
    logic [VAL_W-1:0]    o_level_price;
    logic [VAL_W-1:0]    o_level_qty;
    logic                o_last;

    limit_order_book_matcher uut (.*);

    always #5 i_clk = ~i_clk;

    // behavioral book
    bit                  bk_valid [BOOK_DEPTH];
    bit                  bk_sell  [BOOK_DEPTH];
    logic [VAL_W-1:0]    bk_price [BOOK_DEPTH];
    logic [VAL_W-1:0]    bk_qty   [BOOK_DEPTH];
    logic [TAG_BITS-1:0] bk_tag   [BOOK_DEPTH];
    logic [STAMP_W-1:0]  bk_stamp [BOOK_DEPTH];
    logic [STAMP_W-1:0]  bk_next_stamp;

    t_word pend_q[$];
    t_word expected_words[$];
    t_cmd  dir_q[$];
    t_cmd  cur_cmd;
    int    cur_chk = CHK_MODEL;

    int n_items, n_words, n_trades, n_rejects, n_prints, n_mismatch, n_errors, quiet;

    function automatic int find_order(logic [TAG_BITS-1:0] tg);
        for (int i = 0; i < BOOK_DEPTH; i++)
            if (bk_valid[i] && bk_tag[i] == tg) return i;
        return -1;
    endfunction

    function automatic t_word mk_word(logic [2:0] k, logic [TAG_BITS-1:0] rt,
                                      logic [VAL_W-1:0] rp, logic [VAL_W-1:0] fq,
                                      logic [TAG_BITS-1:0] it, logic [VAL_W-1:0] ip,
                                      logic [VAL_W-1:0] lp, logic [VAL_W-1:0] lq);
        t_word w;
        w.r.kind = k; w.r.rtag = rt; w.r.rprice = rp; w.r.fqty = fq;
        w.r.itag = it; w.r.iprice = ip; w.r.lprice = lp; w.r.lqty = lq;
        w.last = 1'b0;
        return w;
    endfunction

    // append one expected word to the current command's list
    function automatic void queue_word(t_word w);
        pend_q = {pend_q, w};
    endfunction

    task automatic match_order(bit sell, bit imm, logic [VAL_W-1:0] px,
                               logic [VAL_W-1:0] qty, logic [TAG_BITS-1:0] tg);
        logic [VAL_W-1:0] rem;
        int best, slot;
        rem = qty;
        if (px == 0 || qty == 0 || find_order(tg) >= 0) return;
        while (rem > 0) begin
            best = -1;
            for (int i = 0; i < BOOK_DEPTH; i++) begin
                if (!bk_valid[i] || bk_sell[i] == sell) continue;
                if (sell ? (bk_price[i] < px) : (bk_price[i] > px)) continue;
                if (best < 0) best = i;
                else if (bk_price[i] == bk_price[best]) begin
                    if (bk_stamp[i] < bk_stamp[best]) best = i;
                end else if (sell ? (bk_price[i] > bk_price[best])
                                  : (bk_price[i] < bk_price[best])) best = i;
            end
            if (best < 0) break;
            if (bk_qty[best] > rem) begin
                bk_qty[best] -= rem;
                bk_stamp[best] = bk_next_stamp++;
                queue_word(mk_word(KIND_TRADE, bk_tag[best], bk_price[best], rem,
                                   tg, px, '0, '0));
                rem = '0;
            end else begin
                bk_valid[best] = 1'b0;
                queue_word(mk_word(KIND_TRADE, bk_tag[best], bk_price[best],
                                   bk_qty[best], tg, px, '0, '0));
                rem -= bk_qty[best];
            end
        end
        if (rem > 0 && !imm) begin
            slot = -1;
            for (int i = 0; i < BOOK_DEPTH; i++)
                if (!bk_valid[i]) begin slot = i; break; end
            if (slot < 0) begin
                queue_word(mk_word(KIND_REJECT, '0, '0, '0, tg, px, '0, '0));
            end else begin
                bk_valid[slot] = 1'b1; bk_sell[slot] = sell; bk_price[slot] = px;
                bk_qty[slot] = rem; bk_tag[slot] = tg;
                bk_stamp[slot] = bk_next_stamp++;
            end
        end
    endtask

    task automatic list_side(bit sell);
        bit have_bound, found;
        logic [VAL_W-1:0] bound, lvl;
        longint unsigned sum;
        have_bound = 0; bound = '0;
        queue_word(mk_word(sell ? KIND_SELL_HDR : KIND_BUY_HDR,
                           '0, '0, '0, '0, '0, '0, '0));
        forever begin
            found = 0; lvl = '0; sum = 0;
            for (int i = 0; i < BOOK_DEPTH; i++) begin
                if (!bk_valid[i] || bk_sell[i] != sell) continue;
                if (have_bound && bk_price[i] >= bound) continue;
                if (!found || bk_price[i] > lvl) begin lvl = bk_price[i]; found = 1; end
            end
            if (!found) break;
            for (int i = 0; i < BOOK_DEPTH; i++)
                if (bk_valid[i] && bk_sell[i] == sell && bk_price[i] == lvl)
                    sum += bk_qty[i];
            if (sum > VAL_MAX) sum = VAL_MAX;
            queue_word(mk_word(sell ? KIND_SELL_LVL : KIND_BUY_LVL,
                               '0, '0, '0, '0, '0, lvl, VAL_W'(sum)));
            bound = lvl; have_bound = 1;
        end
    endtask

    // advance the book by one accepted command and queue its words
    task automatic book_step(t_cmd c, int chk);
        int k;
        pend_q.delete();
        case (c.func)
            FUNC_SUBMIT: match_order(c.sell, c.imm, c.price, c.qty, c.tag);
            FUNC_CANCEL: begin
                k = find_order(c.tag);
                if (k >= 0) bk_valid[k] = 1'b0;
            end
            FUNC_MODIFY: begin
                if (c.price != 0 && c.qty != 0) begin
                    k = find_order(c.tag);
                    if (k >= 0) begin
                        bk_valid[k] = 1'b0;
                        match_order(c.sell, 1'b0, c.price, c.qty, c.tag);
                    end
                end
            end
            default: begin
                list_side(1'b1);
                list_side(1'b0);
                n_prints++;
            end
        endcase
        if (chk != CHK_MODEL) begin
            pend_q.delete();
            if (chk == CHK_EMPTY) begin
                queue_word(mk_word(KIND_SELL_HDR, '0, '0, '0, '0, '0, '0, '0));
                queue_word(mk_word(KIND_BUY_HDR, '0, '0, '0, '0, '0, '0, '0));
            end else if (chk == CHK_SAT100) begin
                queue_word(mk_word(KIND_SELL_HDR, '0, '0, '0, '0, '0, '0, '0));
                queue_word(mk_word(KIND_SELL_LVL, '0, '0, '0, '0, '0, 31'd100,
                                   VAL_MAX));
                queue_word(mk_word(KIND_BUY_HDR, '0, '0, '0, '0, '0, '0, '0));
            end
        end
        if (pend_q.size() > 0) pend_q[pend_q.size()-1].last = 1'b1;
        expected_words = {expected_words, pend_q};
    endtask

    // accept commands, check words, watch for a hang
    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n) begin
            quiet++;
            if (o_valid) begin
                quiet = 0;
                n_words++;
                if (o_kind == KIND_TRADE) n_trades++;
                if (o_kind == KIND_REJECT) n_rejects++;
                if (expected_words.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: unexpected word kind=%0d", o_kind);
                end else begin
                    w = expected_words.pop_front();
                    if (o_kind !== w.r.kind || o_resting_tag !== w.r.rtag ||
                        o_resting_price !== w.r.rprice || o_fill_qty !== w.r.fqty ||
                        o_incoming_tag !== w.r.itag || o_incoming_price !== w.r.iprice ||
                        o_level_price !== w.r.lprice || o_level_qty !== w.r.lqty ||
                        o_last !== w.last) begin
                        n_mismatch++;
                        if (n_mismatch <= 10) begin
                            $display("MISMATCH word %0d exp k=%0d rt=%0d rp=%0d fq=%0d",
                                     n_words, w.r.kind, w.r.rtag, w.r.rprice, w.r.fqty);
                            $display("  exp it=%0d ip=%0d lp=%0d lq=%0d last=%0d",
                                     w.r.itag, w.r.iprice, w.r.lprice, w.r.lqty, w.last);
                            $display("  got k=%0d rt=%0d rp=%0d fq=%0d it=%0d ip=%0d",
                                     o_kind, o_resting_tag, o_resting_price, o_fill_qty,
                                     o_incoming_tag, o_incoming_price);
                            $display("  got lp=%0d lq=%0d last=%0d",
                                     o_level_price, o_level_qty, o_last);
                        end
                    end
                end
            end
            if (start && !busy) begin
                quiet = 0;
                n_items++;
                book_step(cur_cmd, cur_chk);
            end
            if (quiet >= WATCH_LIMIT) begin
                $display("watchdog: no activity for %0d cycles", WATCH_LIMIT);
                $display("limit_order_book_matcher_test: FAIL");
                $finish;
            end
        end
    end

    task automatic send_word(t_cmd c, int chk, bit allow_idle);
        @(negedge i_clk);
        cur_cmd = c; cur_chk = chk;
        i_func = c.func; i_side_sell = c.sell; i_immediate = c.imm;
        i_limit_price = c.price; i_order_qty = c.qty; i_order_tag = c.tag;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
    endtask

    function automatic t_cmd mk_cmd(logic [1:0] f, bit s, bit im, logic [VAL_W-1:0] p,
                                    logic [VAL_W-1:0] q, logic [TAG_BITS-1:0] t);
        t_cmd c;
        c.func = f; c.sell = s; c.imm = im; c.price = p; c.qty = q; c.tag = t;
        c.chk = CHK_MODEL;
        return c;
    endfunction

    function automatic t_cmd rand_cmd(int mode);
        t_cmd c;
        int r;
        r = $urandom_range(0, 99);
        c = mk_cmd(FUNC_SUBMIT, 1'($urandom_range(0, 1)), ($urandom_range(0, 1) == 0),
                   VAL_W'($urandom_range(1, 20)), VAL_W'($urandom_range(1, 30)),
                   TAG_BITS'($urandom_range(0, 31)));
        if (mode == 1) begin
            c.imm = 1'b0;
            c.price = c.sell ? VAL_W'($urandom_range(51, 100))
                             : VAL_W'($urandom_range(1, 50));
        end else if (mode == 2) begin
            c.price = c.sell ? VAL_W'($urandom_range(1, 30))
                             : VAL_W'($urandom_range(70, 100));
            c.qty = VAL_W'($urandom_range(1, 120));
        end
        if (r < 12) c.func = FUNC_CANCEL;
        else if (r < 24) c.func = FUNC_MODIFY;
        else if (r < 30) c.func = FUNC_PRINT;
        if ($urandom_range(0, 19) == 0) c.tag = TAG_BITS'($urandom);
        if ($urandom_range(0, 19) == 0) c.price = VAL_W'($urandom);
        if ($urandom_range(0, 19) == 0) c.qty = VAL_W'($urandom);
        if ($urandom_range(0, 29) == 0) c.price = '0;
        if ($urandom_range(0, 29) == 0) c.qty = '0;
        return c;
    endfunction

    initial begin
        t_cmd c;
        int mode;
        n_items = 0; n_words = 0; n_trades = 0; n_rejects = 0; n_prints = 0;
        n_mismatch = 0; n_errors = 0; quiet = 0;
        foreach (bk_valid[i]) bk_valid[i] = 1'b0;
        bk_next_stamp = '0;
        cur_cmd = mk_cmd(FUNC_PRINT, 0, 0, '0, '0, '0);

        c = mk_cmd(FUNC_PRINT, 0, 0, 0, 0, 0); c.chk = CHK_EMPTY; dir_q = {dir_q, c};
        c = mk_cmd(FUNC_SUBMIT, 0, 0, 0, 5, 1); c.chk = CHK_NONE; dir_q = {dir_q, c};
        c = mk_cmd(FUNC_SUBMIT, 1, 0, 5, 0, 1); c.chk = CHK_NONE; dir_q = {dir_q, c};
        c = mk_cmd(FUNC_CANCEL, 0, 0, 0, 0, 77); c.chk = CHK_NONE; dir_q = {dir_q, c};
        c = mk_cmd(FUNC_MODIFY, 0, 0, 9, 9, 77); c.chk = CHK_NONE; dir_q = {dir_q, c};
        c = mk_cmd(FUNC_SUBMIT, 1, 0, 100, VAL_MAX, 1); c.chk = CHK_NONE; dir_q = {dir_q, c};
        c = mk_cmd(FUNC_SUBMIT, 1, 0, 100, VAL_MAX, 2); c.chk = CHK_NONE; dir_q = {dir_q, c};
        c = mk_cmd(FUNC_SUBMIT, 1, 0, 100, 5, 1); c.chk = CHK_NONE; dir_q = {dir_q, c};
        c = mk_cmd(FUNC_PRINT, 0, 0, 0, 0, 0); c.chk = CHK_SAT100; dir_q = {dir_q, c};
        dir_q = {dir_q, mk_cmd(FUNC_SUBMIT, 0, 1, VAL_MAX, 3, 16'hFFFF)};
        dir_q = {dir_q, mk_cmd(FUNC_SUBMIT, 1, 0, 90, 10, 3)};
        dir_q = {dir_q, mk_cmd(FUNC_SUBMIT, 0, 0, 1, 7, 4)};
        dir_q = {dir_q, mk_cmd(FUNC_MODIFY, 1, 0, 200, 4, 4)};
        dir_q = {dir_q, mk_cmd(FUNC_MODIFY, 0, 0, 0, 4, 4)};
        dir_q = {dir_q, mk_cmd(FUNC_CANCEL, 0, 0, 0, 0, 1)};
        dir_q = {dir_q, mk_cmd(FUNC_SUBMIT, 0, 1, 150, 20, 5)};
        dir_q = {dir_q, mk_cmd(FUNC_SUBMIT, 1, 0, 1, 50, 6)};
        dir_q = {dir_q, mk_cmd(FUNC_MODIFY, 0, 1, VAL_MAX, 1, 2)};
        dir_q = {dir_q, mk_cmd(FUNC_SUBMIT, 0, 0, VAL_MAX, VAL_MAX, 16'h8000)};
        dir_q = {dir_q, mk_cmd(FUNC_PRINT, 1, 1, VAL_MAX, VAL_MAX, 16'hFFFF)};
        dir_q = {dir_q, mk_cmd(FUNC_CANCEL, 1, 1, VAL_MAX, VAL_MAX, 16'h8000)};
        dir_q = {dir_q, mk_cmd(FUNC_PRINT, 0, 0, 0, 0, 0)};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_q[i]) send_word(dir_q[i], dir_q[i].chk, 1'b1);

        mode = 0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 30 == 0) mode = $urandom_range(0, 2);
            if (i == 120) begin
                @(negedge i_clk);
                start = 1'b0;
                while (expected_words.size() != 0) @(posedge i_clk);
            end
            c = rand_cmd(mode);
            send_word(c, CHK_MODEL, i < N_RANDOM - QUIET_TAIL);
        end
        @(negedge i_clk);
        start = 1'b0;

        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);

        $display("covered %0d commands, %0d words: %0d trades, %0d rejects, %0d prints",
                 n_items, n_words, n_trades, n_rejects, n_prints);
        $display("mismatches %0d, unexpected words %0d, words left over %0d",
                 n_mismatch, n_errors, expected_words.size());
        if (n_mismatch == 0 && n_errors == 0 && expected_words.size() == 0)
            $display("limit_order_book_matcher_test: PASS");
        else
            $display("limit_order_book_matcher_test: FAIL");
        $finish;
    end
endmodule
